/* src/mexp_pkg.sv */
`timescale 1ns / 1ps
// mexp_pkg: shared types and constants of the modular exponentiation block
// no dependencies

package mexp_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPONENT = 1'd0,
    REG_MODULUS  = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_START_ACC = 4'd2,
    OP_START_SQR = 4'd3,
    OP_STEP      = 4'd4,
    OP_WB_BASE   = 4'd5,
    OP_WB_ACC    = 4'd6,
    OP_WB_PW     = 4'd7,
    OP_FINISH    = 4'd8
  } dp_op_e;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
  } dp_status_t;

endpackage

/* src/mexp_dp.sv */
`timescale 1ns / 1ps
// mexp_dp: datapath with exponent shifter, accumulator, base power and an
// interleaved shift-add modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg

module mexp_dp #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  mexp_pkg::dp_op_e    op_i,
  input  logic [W-1:0]        base_i,
  input  logic [W-1:0]        exponent_i,
  input  logic [W-1:0]        modulus_i,
  output mexp_pkg::dp_status_t status_o,
  output logic [W-1:0]        result_o
);

  localparam int unsigned TW = W + 2;

  logic [W-1:0]  e_q, e_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  pw_q, pw_d;
  logic [W-1:0]  opa_q, opa_d;
  logic [W-1:0]  opb_q, opb_d;
  logic [W-1:0]  r_q, r_d;
  logic [W-1:0]  res_q, res_d;

  logic          m_zero;
  logic          m_one;
  logic [TW-1:0] m_ext;
  logic [TW-1:0] m_dbl;
  logic [TW-1:0] t_sum;
  logic [TW-1:0] t_sub1;
  logic [TW-1:0] t_sub2;
  logic [W-1:0]  step_r;

  assign m_zero = (modulus_i == '0);
  assign m_one  = (modulus_i == W'(1));
  assign m_ext  = TW'(modulus_i);
  assign m_dbl  = m_ext << 1;

  // partial remainder doubled plus the selected operand stays below 3m
  assign t_sum  = (TW'(r_q) << 1) + (opa_q[W-1] ? TW'(opb_q) : TW'(0));
  assign t_sub1 = t_sum - m_ext;
  assign t_sub2 = t_sum - m_dbl;

  always_comb begin
    if (m_zero) begin
      step_r = t_sum[W-1:0];
    end else if (t_sum >= m_dbl) begin
      step_r = t_sub2[W-1:0];
    end else if (t_sum >= m_ext) begin
      step_r = t_sub1[W-1:0];
    end else begin
      step_r = t_sum[W-1:0];
    end
  end

  always_comb begin
    e_d   = e_q;
    acc_d = acc_q;
    pw_d  = pw_q;
    opa_d = opa_q;
    opb_d = opb_q;
    r_d   = r_q;
    res_d = res_q;
    unique case (op_i)
      mexp_pkg::OP_LOAD: begin
        e_d   = exponent_i;
        acc_d = ((exponent_i != '0) && m_one) ? W'(0) : W'(1);
        opa_d = base_i;
        opb_d = W'(1);
        r_d   = '0;
      end
      mexp_pkg::OP_START_ACC: begin
        opa_d = acc_q;
        opb_d = pw_q;
        r_d   = '0;
      end
      mexp_pkg::OP_START_SQR: begin
        opa_d = pw_q;
        opb_d = pw_q;
        r_d   = '0;
      end
      mexp_pkg::OP_STEP: begin
        r_d   = step_r;
        opa_d = opa_q << 1;
      end
      mexp_pkg::OP_WB_BASE: begin
        pw_d = r_q;
      end
      mexp_pkg::OP_WB_ACC: begin
        acc_d = r_q;
      end
      mexp_pkg::OP_WB_PW: begin
        pw_d = r_q;
        e_d  = e_q >> 1;
      end
      mexp_pkg::OP_FINISH: begin
        res_d = acc_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    acc_q <= acc_d;
    pw_q  <= pw_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign status_o.e_zero = (e_q == '0);
  assign status_o.e_lsb  = e_q[0];
  assign result_o        = res_q;

endmodule

/* src/mexp_ctrl.sv */
`timescale 1ns / 1ps
// mexp_ctrl: sequencer for base reduction, square-and-multiply steps and the
// output register handshake
// depends on mexp_pkg

module mexp_ctrl #(
  parameter int unsigned W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mexp_pkg::dp_status_t status_i,
  output mexp_pkg::dp_op_e     op_o
);

  localparam int unsigned CW = $clog2(W);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RED     = 9'b000000010,
    S_RED_WB  = 9'b000000100,
    S_CHK     = 9'b000001000,
    S_MACC    = 9'b000010000,
    S_MACC_WB = 9'b000100000,
    S_SQ_ST   = 9'b001000000,
    S_SQ      = 9'b010000000,
    S_SQ_WB   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            last_bit;
  logic            out_free;
  logic            finish;

  assign last_bit = (cnt_q == CW'(W - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_o    = mexp_pkg::OP_IDLE;
    finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = mexp_pkg::OP_LOAD;
          cnt_d   = '0;
          state_d = S_RED;
        end
      end
      S_RED: begin
        op_o  = mexp_pkg::OP_STEP;
        cnt_d = last_bit ? '0 : cnt_q + CW'(1);
        if (last_bit) begin
          state_d = S_RED_WB;
        end
      end
      S_RED_WB: begin
        op_o    = mexp_pkg::OP_WB_BASE;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.e_zero) begin
          if (out_free) begin
            op_o    = mexp_pkg::OP_FINISH;
            finish  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (status_i.e_lsb) begin
          op_o    = mexp_pkg::OP_START_ACC;
          state_d = S_MACC;
        end else begin
          op_o    = mexp_pkg::OP_START_SQR;
          state_d = S_SQ;
        end
      end
      S_MACC: begin
        op_o  = mexp_pkg::OP_STEP;
        cnt_d = last_bit ? '0 : cnt_q + CW'(1);
        if (last_bit) begin
          state_d = S_MACC_WB;
        end
      end
      S_MACC_WB: begin
        op_o    = mexp_pkg::OP_WB_ACC;
        state_d = S_SQ_ST;
      end
      S_SQ_ST: begin
        op_o    = mexp_pkg::OP_START_SQR;
        state_d = S_SQ;
      end
      S_SQ: begin
        op_o  = mexp_pkg::OP_STEP;
        cnt_d = last_bit ? '0 : cnt_q + CW'(1);
        if (last_bit) begin
          state_d = S_SQ_WB;
        end
      end
      S_SQ_WB: begin
        op_o    = mexp_pkg::OP_WB_PW;
        state_d = S_CHK;
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/modular_exponentiation.sv */
`timescale 1ns / 1ps
// Modular exponentiation: power_result = base_value ** exponent mod modulus,
// computed by right-to-left square-and-multiply over the low WORD_BITS bits.
// One item is in work at a time. After the input transfer the base is first
// reduced mod the modulus; each exponent bit up to the highest set one then
// takes a check state plus a squaring, and a set bit adds a multiply, all on
// one shared shift-add modular multiplier that handles one multiplier bit
// per cycle. The work per item is set by the position and count of set
// exponent bits. A zero exponent returns 1; a zero modulus makes the
// arithmetic wrap mod 2**WORD_BITS. The user must write the registers only
// while no item is in work; the block itself does not enforce this. The
// result register lets the next item enter while a finished result waits
// for transfer.
// depends on mexp_pkg, mexp_ctrl, mexp_dp

module modular_exponentiation #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mexp_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mexp_pkg::DATA_W-1:0]      base_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mexp_pkg::DATA_W-1:0]      power_result_o
);

  logic [WORD_BITS-1:0]  exponent_q;
  logic [WORD_BITS-1:0]  modulus_q;
  logic [WORD_BITS-1:0]  result;
  mexp_pkg::dp_op_e      op;
  mexp_pkg::dp_status_t  status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= WORD_BITS'(1);
      modulus_q  <= WORD_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mexp_pkg::cfg_reg_e'(cfg_index_i))
        mexp_pkg::REG_EXPONENT: exponent_q <= cfg_data_i[WORD_BITS-1:0];
        mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data_i[WORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mexp_ctrl #(
    .W (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .op_o        (op)
  );

  mexp_dp #(
    .W (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .op_i       (op),
    .base_i     (base_value_i[WORD_BITS-1:0]),
    .exponent_i (exponent_q),
    .modulus_i  (modulus_q),
    .status_o   (status),
    .result_o   (result)
  );

  assign power_result_o = mexp_pkg::DATA_W'(result);

endmodule
